// ===== src/bnr_pkg.sv =====
// Shared types, constants and helpers for the boundary node renumbering block.
package bnr_pkg;

  localparam int NODE_W    = 13;
  localparam int MAX_NODES = 4096;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = 3;

  localparam logic [ADDR_W-1:0] MAP_LAST    = ADDR_W'(MAX_NODES - 1);
  localparam logic [NODE_W-1:0] MAX_LIVE    = NODE_W'(MAX_NODES);
  localparam logic [CNT_W-1:0]  CORNERS_QUAD = CNT_W'(4);
  localparam logic [NODE_W-1:0] FLAG_MARK   = NODE_W'(1);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERIOR_MODE = 1'b1;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_MARK   = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_FINISH = 2'd0,
    ST_LOOKUP = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_MARK,
    S_FIN_RD,
    S_FIN_WR,
    S_LOOK,
    S_EMIT
  } state_t;

  typedef struct packed {
    cmd_t              command;
    logic [NODE_W-1:0] corner_a;
    logic [NODE_W-1:0] corner_b;
    logic [NODE_W-1:0] corner_c;
    logic [NODE_W-1:0] corner_d;
    logic [CNT_W-1:0]  corner_count;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [NODE_W-1:0] new_index;
    logic [NODE_W-1:0] boundary_count;
    logic              boundary_first;
  } result_t;

  function automatic logic [NODE_W-1:0] live_count(input logic [NODE_W-1:0] count);
    return (count > MAX_LIVE) ? MAX_LIVE : count;
  endfunction

  function automatic logic in_range(input logic [NODE_W-1:0] node,
                                    input logic [NODE_W-1:0] live);
    return (node != '0) && (node <= live);
  endfunction

  function automatic logic [ADDR_W-1:0] node_addr(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] off;
    off = node - NODE_W'(1);
    return off[ADDR_W-1:0];
  endfunction

endpackage

// ===== src/bnr_map_ram.sv =====
// Node map memory: one write port, one registered read port.
module bnr_map_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [bnr_pkg::ADDR_W-1:0]   waddr,
  input  logic [bnr_pkg::NODE_W-1:0]   wdata,
  input  logic [bnr_pkg::ADDR_W-1:0]   raddr,
  output logic [bnr_pkg::NODE_W-1:0]   rdata
);

  logic [bnr_pkg::NODE_W-1:0] mem [bnr_pkg::MAX_NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/boundary_node_renumber.sv =====
// Boundary node renumbering: command sequencer around the node map memory.
//
// Items arrive on item/item_valid/item_stall; a beat moves when valid is high
// and stall is low. Results leave on result/result_valid/result_stall the same
// way. Registers node_count and interior_mode are written on the cfg channel
// (cfg_ready is always high) by the user only while the block is idle; the block
// does not enforce this. One item is worked at a time, and item_stall is high
// while one is in progress. Work per item, from the accept beat until the next is taken:
//   clear          every map entry zeroed, one per cycle
//   mark           one corner written per cycle; none on error
//   lookup         one map read; none on error
//   finish         a map read then a write back per node and pass
// A finished result sits in the output register while the next item is
// accepted; a stalled receiver holds the result and the block waits before
// its next result. After reset the whole map is cleared, while item_stall
// stays high; configuration writes are taken throughout.
module boundary_node_renumber (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  bnr_pkg::item_t                    item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output bnr_pkg::result_t                  result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bnr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bnr_pkg::NODE_W-1:0]        cfg_data
);

  localparam int NW = bnr_pkg::NODE_W;
  localparam int AW = bnr_pkg::ADDR_W;

  logic [NW-1:0] node_count;
  logic          interior_mode;

  bnr_pkg::state_t  state, state_next;
  logic [AW-1:0]    idx;
  logic [NW-1:0]    rank;
  logic             pass2;
  logic [NW-1:0]    corners [4];
  logic [1:0]       k;
  logic             quad;
  logic [NW-1:0]    largest;
  logic [NW-1:0]    boundary_total;
  bnr_pkg::result_t res;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [NW-1:0] wdata, rdata;

  logic [NW-1:0] live, live_m1, rank_inc, rank_new, fin_count;
  logic          accept, mark_ok, look_ok, idx_last, match, slot_free, mark_last;
  logic          fin_end, fin_done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count    <= '0;
      interior_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bnr_pkg::CFG_NODE_COUNT:    node_count    <= cfg_data;
        bnr_pkg::CFG_INTERIOR_MODE: interior_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign live      = bnr_pkg::live_count(node_count);
  assign live_m1   = live - NW'(1);
  assign accept    = item_valid && !item_stall;
  assign item_stall = (state != bnr_pkg::S_IDLE);
  assign look_ok   = bnr_pkg::in_range(item.corner_a, live);
  assign mark_ok   = look_ok
                     && bnr_pkg::in_range(item.corner_b, live)
                     && bnr_pkg::in_range(item.corner_c, live)
                     && ((item.corner_count != bnr_pkg::CORNERS_QUAD)
                         || bnr_pkg::in_range(item.corner_d, live));
  assign idx_last  = ({1'b0, idx} == live_m1);
  assign match     = pass2 ? (rdata == '0) : (rdata == bnr_pkg::FLAG_MARK);
  assign rank_inc  = rank + NW'(1);
  assign rank_new  = match ? rank_inc : rank;
  assign fin_count = pass2 ? boundary_total : rank_new;
  assign fin_end   = idx_last && (pass2 || !interior_mode);
  assign fin_done  = (state == bnr_pkg::S_FIN_WR) && fin_end;
  assign slot_free = !result_valid || !result_stall;
  assign mark_last = (k == (quad ? 2'd3 : 2'd2));

  always_comb begin
    state_next = state;
    unique case (state)
      bnr_pkg::S_IDLE: begin
        if (accept) begin
          unique case (item.command)
            bnr_pkg::CMD_CLEAR:  state_next = bnr_pkg::S_CLEAR;
            bnr_pkg::CMD_MARK:   state_next = mark_ok ? bnr_pkg::S_MARK : bnr_pkg::S_EMIT;
            bnr_pkg::CMD_FINISH: state_next = (live == '0) ? bnr_pkg::S_EMIT
                                                             : bnr_pkg::S_FIN_RD;
            bnr_pkg::CMD_LOOKUP: state_next = look_ok ? bnr_pkg::S_LOOK : bnr_pkg::S_EMIT;
            default:             state_next = bnr_pkg::S_IDLE;
          endcase
        end
      end
      bnr_pkg::S_CLEAR:  if (idx == bnr_pkg::MAP_LAST) state_next = bnr_pkg::S_IDLE;
      bnr_pkg::S_MARK:   if (mark_last) state_next = bnr_pkg::S_IDLE;
      bnr_pkg::S_FIN_RD: state_next = bnr_pkg::S_FIN_WR;
      bnr_pkg::S_FIN_WR: state_next = fin_end ? bnr_pkg::S_EMIT : bnr_pkg::S_FIN_RD;
      bnr_pkg::S_LOOK:   state_next = bnr_pkg::S_EMIT;
      bnr_pkg::S_EMIT:   if (slot_free) state_next = bnr_pkg::S_IDLE;
      default:           state_next = bnr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = '0;
    raddr = idx;
    unique case (state)
      bnr_pkg::S_IDLE:   raddr = bnr_pkg::node_addr(item.corner_a);
      bnr_pkg::S_CLEAR:  we = 1'b1;
      bnr_pkg::S_MARK: begin
        we    = 1'b1;
        waddr = bnr_pkg::node_addr(corners[k]);
        wdata = bnr_pkg::FLAG_MARK;
      end
      bnr_pkg::S_FIN_WR: begin
        we    = match;
        wdata = rank_inc;
      end
      default: ;
    endcase
  end

  bnr_map_ram u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= bnr_pkg::S_CLEAR;
      idx            <= '0;
      largest        <= '0;
      boundary_total <= '0;
      result_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bnr_pkg::S_EMIT && slot_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        bnr_pkg::S_IDLE: begin
          if (accept) begin
            idx <= '0;
            if (item.command == bnr_pkg::CMD_CLEAR) begin
              largest        <= '0;
              boundary_total <= '0;
            end
            if (item.command == bnr_pkg::CMD_FINISH && live == '0) begin
              boundary_total <= '0;
            end
          end
        end
        bnr_pkg::S_CLEAR: idx <= idx + AW'(1);
        bnr_pkg::S_MARK: begin
          if (corners[k] > largest) begin
            largest <= corners[k];
          end
        end
        bnr_pkg::S_FIN_WR: begin
          if (idx_last) begin
            idx <= '0;
            if (!pass2) begin
              boundary_total <= rank_new;
            end
          end else begin
            idx <= idx + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == bnr_pkg::S_IDLE && accept) begin
      corners[0] <= item.corner_a;
      corners[1] <= item.corner_b;
      corners[2] <= item.corner_c;
      corners[3] <= item.corner_d;
      quad       <= (item.corner_count == bnr_pkg::CORNERS_QUAD);
      k          <= '0;
      rank       <= '0;
      pass2      <= 1'b0;
      unique case (item.command)
        bnr_pkg::CMD_MARK: begin
          if (!mark_ok) begin
            res <= '{status: bnr_pkg::ST_RANGE, new_index: '0,
                      boundary_count: '0, boundary_first: 1'b0};
          end
        end
        bnr_pkg::CMD_FINISH: begin
          res <= '{status: bnr_pkg::ST_FINISH, new_index: '0,
                    boundary_count: '0, boundary_first: (largest == '0)};
        end
        bnr_pkg::CMD_LOOKUP: begin
          if (!look_ok) begin
            res <= '{status: bnr_pkg::ST_RANGE, new_index: '0,
                      boundary_count: '0, boundary_first: 1'b0};
          end
        end
        default: ;
      endcase
    end
    if (state == bnr_pkg::S_MARK) begin
      k <= k + 2'd1;
    end
    if (state == bnr_pkg::S_FIN_WR) begin
      rank <= rank_new;
      if (idx_last && !pass2 && interior_mode) begin
        pass2 <= 1'b1;
      end
    end
    if (fin_done) begin
      res <= '{status: bnr_pkg::ST_FINISH, new_index: '0,
               boundary_count: fin_count, boundary_first: (fin_count == largest)};
    end
    if (state == bnr_pkg::S_LOOK) begin
      res <= '{status: bnr_pkg::ST_LOOKUP, new_index: rdata,
               boundary_count: '0, boundary_first: 1'b0};
    end
    if (state == bnr_pkg::S_EMIT && slot_free) begin
      result <= res;
    end
  end

endmodule

// ===== dv/tb_boundary_node_renumber.sv =====
// Self-checking testbench for the boundary node renumbering block.
module tb_boundary_node_renumber;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NW       = bnr_pkg::NODE_W;
  localparam int CW       = bnr_pkg::CNT_W;
  localparam int NODE_TOP = (1 << NW) - 1;
  localparam int SETTLE   = bnr_pkg::MAX_NODES + 16;

  class renumber_scoreboard;
    logic [NW-1:0]     entry_rank [bnr_pkg::MAX_NODES];
    logic [NW-1:0]     largest_corner;
    logic [NW-1:0]     boundary_total;
    logic [NW-1:0]     node_count;
    logic              interior_mode;
    bnr_pkg::result_t  pending_answers [$];
    int                failures;

    function new();
      foreach (entry_rank[i]) entry_rank[i] = '0;
      largest_corner = '0;
      boundary_total = '0;
      node_count     = '0;
      interior_mode  = 1'b0;
      failures       = 0;
    endfunction

    function void write_reg(logic [bnr_pkg::CFG_IDX_W-1:0] idx, logic [NW-1:0] data);
      if (idx == bnr_pkg::CFG_NODE_COUNT) begin
        node_count = data;
      end else begin
        interior_mode = data[0];
      end
    endfunction

    function int usable_nodes();
      return (node_count > bnr_pkg::MAX_LIVE) ? int'(bnr_pkg::MAX_LIVE) : int'(node_count);
    endfunction

    function void apply_command(bnr_pkg::item_t it);
      logic [NW-1:0]     corner [4];
      logic [NW-1:0]     rank;
      bnr_pkg::result_t  ans;
      int                live;
      int                used;
      bit                bad;
      bit                answered;
      corner[0] = it.corner_a;
      corner[1] = it.corner_b;
      corner[2] = it.corner_c;
      corner[3] = it.corner_d;
      live      = usable_nodes();
      ans       = '0;
      answered  = 1'b0;
      case (it.command)
        bnr_pkg::CMD_CLEAR: begin
          foreach (entry_rank[i]) entry_rank[i] = '0;
          largest_corner = '0;
          boundary_total = '0;
        end
        bnr_pkg::CMD_MARK: begin
          used = (it.corner_count == bnr_pkg::CORNERS_QUAD) ? 4 : 3;
          bad  = 1'b0;
          for (int k = 0; k < used; k++) begin
            if (corner[k] == '0 || int'(corner[k]) > live) bad = 1'b1;
          end
          if (bad) begin
            ans.status = bnr_pkg::ST_RANGE;
            answered   = 1'b1;
          end else begin
            for (int k = 0; k < used; k++) begin
              entry_rank[int'(corner[k]) - 1] = bnr_pkg::FLAG_MARK;
              if (corner[k] > largest_corner) largest_corner = corner[k];
            end
          end
        end
        bnr_pkg::CMD_FINISH: begin
          rank = '0;
          for (int i = 0; i < live; i++) begin
            if (entry_rank[i] == bnr_pkg::FLAG_MARK) begin
              rank          = rank + NW'(1);
              entry_rank[i] = rank;
            end
          end
          boundary_total = rank;
          if (interior_mode) begin
            for (int i = 0; i < live; i++) begin
              if (entry_rank[i] == '0) begin
                rank          = rank + NW'(1);
                entry_rank[i] = rank;
              end
            end
          end
          ans.status         = bnr_pkg::ST_FINISH;
          ans.boundary_count = boundary_total;
          ans.boundary_first = (boundary_total == largest_corner);
          answered           = 1'b1;
        end
        default: begin
          if (corner[0] == '0 || int'(corner[0]) > live) begin
            ans.status = bnr_pkg::ST_RANGE;
          end else begin
            ans.status    = bnr_pkg::ST_LOOKUP;
            ans.new_index = entry_rank[int'(corner[0]) - 1];
          end
          answered = 1'b1;
        end
      endcase
      if (answered) pending_answers.push_back(ans);
    endfunction

    function void compare_answer(bnr_pkg::result_t got);
      bnr_pkg::result_t want;
      if (pending_answers.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: status %0d idx %0d cnt %0d first %0d",
                   got.status, got.new_index, got.boundary_count, got.boundary_first);
        return;
      end
      want = pending_answers.pop_front();
      if (got.status !== want.status || got.new_index !== want.new_index ||
          got.boundary_count !== want.boundary_count ||
          got.boundary_first !== want.boundary_first) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: exp status %0d idx %0d cnt %0d first %0d, got %0d %0d %0d %0d",
                   want.status, want.new_index, want.boundary_count, want.boundary_first,
                   got.status, got.new_index, got.boundary_count, got.boundary_first);
      end
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction
  endclass

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          item_valid   = 1'b0;
  logic                          item_stall;
  bnr_pkg::item_t                item         = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  bnr_pkg::result_t              result;
  logic                          cfg_valid    = 1'b0;
  logic                          cfg_ready;
  logic [bnr_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
  logic [NW-1:0]                 cfg_data     = '0;

  renumber_scoreboard   sb;
  bit                   calm;
  int                   hold_req;
  int                   hold_seen;
  int                   hold_left;
  logic [NW-1:0]        recent_nodes [$];

  boundary_node_renumber dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.compare_answer(result);
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !calm && ($urandom_range(0, 99) < 14);
    end
  end

  function automatic logic [NW-1:0] rnd_node();
    return NW'($urandom_range(0, NODE_TOP));
  endfunction

  function automatic logic [NW-1:0] node_in(input int span);
    return NW'($urandom_range(1, (span < 1) ? 1 : span));
  endfunction

  function automatic logic [NW-1:0] node_out(input int live);
    if (live >= NODE_TOP || $urandom_range(0, 3) == 0) return '0;
    return NW'($urandom_range(live + 1, NODE_TOP));
  endfunction

  function automatic logic [CW-1:0] tri_count();
    logic [CW-1:0] n;
    do n = CW'($urandom_range(0, 7)); while (n == bnr_pkg::CORNERS_QUAD);
    return n;
  endfunction

  function automatic bnr_pkg::item_t mk_item(input bnr_pkg::cmd_t cmd, input int a,
                                             input int b, input int c, input int d,
                                             input int cnt);
    bnr_pkg::item_t it;
    it.command      = cmd;
    it.corner_a     = NW'(a);
    it.corner_b     = NW'(b);
    it.corner_c     = NW'(c);
    it.corner_d     = NW'(d);
    it.corner_count = CW'(cnt);
    return it;
  endfunction

  task automatic send_item(input bnr_pkg::item_t it);
    while (!calm && $urandom_range(0, 99) < 14) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.apply_command(it);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bnr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [NW-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input int count, input bit mode);
    write_reg(bnr_pkg::CFG_NODE_COUNT, NW'(count));
    write_reg(bnr_pkg::CFG_INTERIOR_MODE, NW'(mode));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_mark(input int span, input bit broken);
    logic [NW-1:0] c [4];
    bit            quad;
    int            live;
    live = sb.usable_nodes();
    quad = $urandom_range(0, 1);
    for (int k = 0; k < 4; k++) c[k] = node_in(span);
    if (!quad) c[3] = rnd_node();
    if (broken) begin
      c[$urandom_range(0, quad ? 3 : 2)] = node_out(live);
    end else begin
      for (int k = 0; k < (quad ? 4 : 3); k++) recent_nodes.push_back(c[k]);
      while (recent_nodes.size() > 32) void'(recent_nodes.pop_front());
    end
    send_item(mk_item(bnr_pkg::CMD_MARK, c[0], c[1], c[2], c[3],
                      quad ? bnr_pkg::CORNERS_QUAD : tri_count()));
  endtask

  task automatic send_lookup(input int live);
    logic [NW-1:0] node;
    int            pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      node = node_out(live);
    end else if (pick < 6 && recent_nodes.size() != 0) begin
      node = recent_nodes[$urandom_range(0, recent_nodes.size() - 1)];
    end else begin
      node = node_in(live);
    end
    send_item(mk_item(bnr_pkg::CMD_LOOKUP, node, rnd_node(), rnd_node(), rnd_node(),
                      $urandom_range(0, 7)));
  endtask

  task automatic run_sequences(input int budget);
    int            sent;
    int            live;
    int            span;
    bnr_pkg::cmd_t cmd;
    sent = 0;
    while (sent < budget) begin
      live = sb.usable_nodes();
      span = (live == 0) ? 1 : $urandom_range(1, live);
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 2) == 0) begin
          send_item(mk_item(bnr_pkg::CMD_CLEAR, rnd_node(), rnd_node(), rnd_node(),
                            rnd_node(), $urandom_range(0, 7)));
          recent_nodes.delete();
          sent++;
        end
        repeat ($urandom_range(1, 8)) begin
          send_mark(span, $urandom_range(0, 9) == 0);
          sent++;
        end
        send_item(mk_item(bnr_pkg::CMD_FINISH, rnd_node(), rnd_node(), rnd_node(),
                          rnd_node(), $urandom_range(0, 7)));
        sent++;
        repeat ($urandom_range(2, 8)) begin
          send_lookup(live);
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          cmd = bnr_pkg::cmd_t'($urandom_range(0, 3));
          if (cmd == bnr_pkg::CMD_CLEAR && $urandom_range(0, 3) != 0) begin
            cmd = bnr_pkg::CMD_LOOKUP;
          end
          send_item(mk_item(cmd, rnd_node(), rnd_node(), rnd_node(), rnd_node(),
                            $urandom_range(0, 7)));
          sent++;
        end
      end
    end
  endtask

  task automatic run_directed();
    send_item(mk_item(bnr_pkg::CMD_LOOKUP, 1, 0, 0, 0, 3));
    send_item(mk_item(bnr_pkg::CMD_LOOKUP, 0, 0, 0, 0, 3));
    send_item(mk_item(bnr_pkg::CMD_LOOKUP, 9, 0, 0, 0, 3));
    send_item(mk_item(bnr_pkg::CMD_FINISH, 0, 0, 0, 0, 0));
    send_item(mk_item(bnr_pkg::CMD_MARK, 1, 2, 3, 0, 3));
    send_item(mk_item(bnr_pkg::CMD_MARK, 3, 4, 5, 6, bnr_pkg::CORNERS_QUAD));
    send_item(mk_item(bnr_pkg::CMD_MARK, 8, 2, 1, NODE_TOP, 7));
    send_item(mk_item(bnr_pkg::CMD_MARK, 1, 0, 3, 0, 3));
    send_item(mk_item(bnr_pkg::CMD_MARK, 1, 2, 3, 9, bnr_pkg::CORNERS_QUAD));
    send_item(mk_item(bnr_pkg::CMD_MARK, 1, 2, NODE_TOP, 0, 3));
    send_item(mk_item(bnr_pkg::CMD_FINISH, 0, 0, 0, 0, 0));
    send_item(mk_item(bnr_pkg::CMD_LOOKUP, 8, 0, 0, 0, 0));
    send_item(mk_item(bnr_pkg::CMD_LOOKUP, 7, 0, 0, 0, 0));
    send_item(mk_item(bnr_pkg::CMD_MARK, 7, 7, 7, 0, 3));
    send_item(mk_item(bnr_pkg::CMD_FINISH, 0, 0, 0, 0, 0));
    send_item(mk_item(bnr_pkg::CMD_LOOKUP, 7, 0, 0, 0, 0));
    send_item(mk_item(bnr_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
    send_item(mk_item(bnr_pkg::CMD_LOOKUP, 3, 0, 0, 0, 0));
    drain();
    configure(8, 1'b1);
    send_item(mk_item(bnr_pkg::CMD_MARK, 2, 5, 5, 0, 3));
    send_item(mk_item(bnr_pkg::CMD_FINISH, 0, 0, 0, 0, 0));
    send_item(mk_item(bnr_pkg::CMD_LOOKUP, 1, 0, 0, 0, 0));
    send_item(mk_item(bnr_pkg::CMD_LOOKUP, 5, 0, 0, 0, 0));
    drain();
    configure(NODE_TOP, 1'b0);
    send_item(mk_item(bnr_pkg::CMD_LOOKUP, bnr_pkg::MAX_NODES + 1, 0, 0, 0, 0));
    send_item(mk_item(bnr_pkg::CMD_MARK, bnr_pkg::MAX_NODES, 1, 2048, bnr_pkg::MAX_NODES,
                      bnr_pkg::CORNERS_QUAD));
    send_item(mk_item(bnr_pkg::CMD_FINISH, 0, 0, 0, 0, 0));
    send_item(mk_item(bnr_pkg::CMD_LOOKUP, bnr_pkg::MAX_NODES, 0, 0, 0, 0));
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    configure(8, 1'b0);
    run_directed();

    drain();
    configure($urandom_range(1, 40), $urandom_range(0, 1));
    run_sequences(150);

    drain();
    configure(bnr_pkg::MAX_NODES, 1'b1);
    run_sequences(40);

    drain();
    calm = 1'b1;
    configure($urandom_range(1, 40), $urandom_range(0, 1));
    run_sequences(150);

    drain();
    calm = 1'b0;
    configure(0, $urandom_range(0, 1));
    run_sequences(20);

    drain();
    configure(NODE_TOP, 1'b0);
    run_sequences(40);

    drain();
    configure($urandom_range(1, 64), 1'b1);
    hold_req++;
    repeat (20) send_lookup(sb.usable_nodes());
    run_sequences(120);

    repeat (4) begin
      drain();
      configure($urandom_range(1, 200), $urandom_range(0, 1));
      run_sequences(130);
    end

    drain();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
src/bnr_pkg.sv
src/bnr_map_ram.sv
src/boundary_node_renumber.sv
dv/tb_boundary_node_renumber.sv
